[src/hpt_pkg.sv]
// Shared types, codes and helpers for the homogeneous point transform.
package hpt_pkg;

	localparam int unsigned COORD_WIDTH_DEF = 32;
	localparam int unsigned FRAC_BITS_DEF = 16;

	localparam logic [1:0] FUNC_WRITE = 2'd0;
	localparam logic [1:0] FUNC_POINT = 2'd1;
	localparam logic [1:0] FUNC_VECTOR = 2'd2;

	localparam int unsigned FORM_TRANSLATE = 0;
	localparam int unsigned FORM_SCALE = 1;
	localparam int unsigned FORM_ROTATE = 2;
	localparam int unsigned FORM_PERSP = 3;

	typedef struct packed {
		logic load;
		logic issue;
	} mac_ctrl_t;

	typedef struct packed {
		logic done;
		logic sat;
	} div_stat_t;

	function automatic logic is_diag(input logic [3:0] idx);
		return idx[3:2] == idx[1:0];
	endfunction

	function automatic logic [3:0] form_of(input logic [15:0] dev);
		logic [3:0] f;
		f[FORM_TRANSLATE] = dev[3] | dev[7] | dev[11];
		f[FORM_SCALE] = dev[0] | dev[5] | dev[10];
		f[FORM_ROTATE] = dev[1] | dev[2] | dev[4] | dev[6] | dev[8] | dev[9];
		f[FORM_PERSP] = dev[12] | dev[13] | dev[14] | dev[15];
		return f;
	endfunction

endpackage

[src/hpt_mac.sv]
// Shared multiply-accumulate unit: one digit product per cycle into a wide accumulator.
module hpt_mac #(
	parameter int unsigned COORD_WIDTH = hpt_pkg::COORD_WIDTH_DEF,
	localparam int unsigned NDIG = (COORD_WIDTH + 31) / 32,
	localparam int unsigned DI_W = (NDIG > 1) ? $clog2(NDIG) : 1,
	localparam int unsigned ACC_W = 2 * COORD_WIDTH + 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hpt_pkg::mac_ctrl_t            ctrl,
	input  logic [ACC_W-1:0]              init,
	input  logic signed [COORD_WIDTH-1:0] a,
	input  logic signed [COORD_WIDTH-1:0] b,
	input  logic [DI_W-1:0]               da,
	input  logic [DI_W-1:0]               db,
	output logic [ACC_W-1:0]              acc
);

	localparam int unsigned DIG_W = (COORD_WIDTH + NDIG - 1) / NDIG;
	localparam int unsigned MAG_W = NDIG * DIG_W;
	localparam int unsigned DS_W = DI_W + 1;

	logic [COORD_WIDTH-1:0] abs_a;
	logic [COORD_WIDTH-1:0] abs_b;
	logic [DIG_W-1:0]       dig_a;
	logic [DIG_W-1:0]       dig_b;
	logic [ACC_W-1:0]       addend;

	logic                v_s1;
	logic                neg_s1;
	logic [MAG_W-1:0]    mag_a_s1;
	logic [MAG_W-1:0]    mag_b_s1;
	logic [DI_W-1:0]     da_s1;
	logic [DI_W-1:0]     db_s1;
	logic                v_s2;
	logic                neg_s2;
	logic [2*DIG_W-1:0]  prod_s2;
	logic [DS_W-1:0]     dsum_s2;
	logic [ACC_W-1:0]    acc_q;

	assign abs_a = a[COORD_WIDTH-1] ? (~a + 1'b1) : a;
	assign abs_b = b[COORD_WIDTH-1] ? (~b + 1'b1) : b;
	assign dig_a = mag_a_s1[da_s1 * DIG_W +: DIG_W];
	assign dig_b = mag_b_s1[db_s1 * DIG_W +: DIG_W];
	assign addend = ACC_W'(prod_s2) << (dsum_s2 * DIG_W);
	assign acc = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			neg_s1 <= 1'b0;
			mag_a_s1 <= '0;
			mag_b_s1 <= '0;
			da_s1 <= '0;
			db_s1 <= '0;
			v_s2 <= 1'b0;
			neg_s2 <= 1'b0;
			prod_s2 <= '0;
			dsum_s2 <= '0;
			acc_q <= '0;
		end else begin
			v_s1 <= ctrl.issue;
			neg_s1 <= a[COORD_WIDTH-1] ^ b[COORD_WIDTH-1];
			mag_a_s1 <= MAG_W'(abs_a);
			mag_b_s1 <= MAG_W'(abs_b);
			da_s1 <= da;
			db_s1 <= db;
			v_s2 <= v_s1;
			neg_s2 <= neg_s1;
			prod_s2 <= (2 * DIG_W)'(dig_a) * (2 * DIG_W)'(dig_b);
			dsum_s2 <= DS_W'(da_s1) + DS_W'(db_s1);
			if (ctrl.load) begin
				acc_q <= init;
			end else if (v_s2) begin
				acc_q <= acc_q + (addend ^ {ACC_W{neg_s2}}) + ACC_W'(neg_s2);
			end
		end
	end

	a_load_drained: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load |-> !v_s1 && !v_s2)
		else $error("accumulator loaded while products are in flight");

endmodule

[src/hpt_div.sv]
// Iterative restoring divider: num * 2^FRAC_BITS / den, rounded half away from zero, saturated.
module hpt_div #(
	parameter int unsigned COORD_WIDTH = hpt_pkg::COORD_WIDTH_DEF,
	parameter int unsigned FRAC_BITS = hpt_pkg::FRAC_BITS_DEF,
	localparam int unsigned ACC_W = 2 * COORD_WIDTH + 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [ACC_W-1:0]       num,
	input  logic [ACC_W-1:0]       den,
	output logic [COORD_WIDTH-1:0] quo,
	output hpt_pkg::div_stat_t     stat
);

	localparam int unsigned RW = ACC_W + COORD_WIDTH;
	localparam int unsigned CNT_W = $clog2(COORD_WIDTH + 1);
	localparam logic [COORD_WIDTH:0] LIM_NEG = (COORD_WIDTH + 1)'(1) << (COORD_WIDTH - 1);
	localparam logic [COORD_WIDTH:0] LIM_POS = LIM_NEG - (COORD_WIDTH + 1)'(1);
	localparam logic [COORD_WIDTH-1:0] MAX_C = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
	localparam logic [COORD_WIDTH-1:0] MIN_C = {1'b1, {(COORD_WIDTH - 1){1'b0}}};

	typedef enum logic [2:0] {
		D_IDLE,
		D_CHECK,
		D_STEP,
		D_ROUND,
		D_DONE
	} dstate_t;

	dstate_t               st_q;
	logic                  neg_q;
	logic [ACC_W-1:0]      num_abs_q;
	logic [ACC_W-1:0]      den_abs_q;
	logic [RW-1:0]         rem_q;
	logic [COORD_WIDTH:0]  qb_q;
	logic [COORD_WIDTH:0]  qr_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [COORD_WIDTH-1:0] quo_q;
	logic                  sat_q;
	logic                  done_q;

	logic [ACC_W-1:0] num_abs;
	logic [ACC_W-1:0] den_abs;
	logic [RW-1:0]    dshift;
	logic [RW:0]      diff;
	logic             ge;
	logic [RW-1:0]    rem_next;
	logic             ovf;
	logic             over;

	assign num_abs = num[ACC_W-1] ? (~num + 1'b1) : num;
	assign den_abs = den[ACC_W-1] ? (~den + 1'b1) : den;
	assign dshift = RW'(den_abs_q) << (COORD_WIDTH - 1);
	assign diff = {1'b0, rem_q} - {1'b0, dshift};
	assign ge = !diff[RW];
	assign rem_next = ge ? diff[RW-1:0] : rem_q;
	assign ovf = (RW'(num_abs_q) << FRAC_BITS) >= (RW'(den_abs_q) << COORD_WIDTH);
	assign over = qr_q > (neg_q ? LIM_NEG : LIM_POS);

	assign quo = quo_q;
	assign stat.done = done_q;
	assign stat.sat = sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= D_IDLE;
			neg_q <= 1'b0;
			num_abs_q <= '0;
			den_abs_q <= '0;
			rem_q <= '0;
			qb_q <= '0;
			qr_q <= '0;
			cnt_q <= '0;
			quo_q <= '0;
			sat_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				D_IDLE: begin
					if (start) begin
						num_abs_q <= num_abs;
						den_abs_q <= den_abs;
						neg_q <= num[ACC_W-1] ^ den[ACC_W-1];
						st_q <= D_CHECK;
					end
				end
				D_CHECK: begin
					if (ovf) begin
						quo_q <= neg_q ? MIN_C : MAX_C;
						sat_q <= 1'b1;
						done_q <= 1'b1;
						st_q <= D_IDLE;
					end else begin
						rem_q <= RW'(num_abs_q) << FRAC_BITS;
						qb_q <= '0;
						cnt_q <= '0;
						st_q <= D_STEP;
					end
				end
				D_STEP: begin
					rem_q <= rem_next << 1;
					qb_q <= {qb_q[COORD_WIDTH-1:0], ge};
					if (cnt_q == CNT_W'(COORD_WIDTH)) begin
						st_q <= D_ROUND;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				D_ROUND: begin
					qr_q <= {1'b0, qb_q[COORD_WIDTH:1]} + (COORD_WIDTH + 1)'(qb_q[0]);
					st_q <= D_DONE;
				end
				D_DONE: begin
					if (over) begin
						quo_q <= neg_q ? MIN_C : MAX_C;
					end else if (neg_q) begin
						quo_q <= (~qr_q[COORD_WIDTH-1:0]) + 1'b1;
					end else begin
						quo_q <= qr_q[COORD_WIDTH-1:0];
					end
					sat_q <= over;
					done_q <= 1'b1;
					st_q <= D_IDLE;
				end
				default: st_q <= D_IDLE;
			endcase
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> st_q == D_IDLE)
		else $error("division started while busy");

endmodule

[src/homogeneous_point_transform.sv]
// Top level of the homogeneous 4x4 point transform with one shared multiply-accumulate unit.
// Matrix write: ready stays high. Vector or affine point: 3 rows of 3*D*D digit
// products each, D = ceil(COORD_WIDTH/32). Perspective point: the w row, then, unless
// w is zero, 3 more rows each followed by a division; a stalled result holds the item.
// Reset: the matrix reads as identity, form flags clear, no output pending.
module homogeneous_point_transform #(
	parameter int unsigned COORD_WIDTH = hpt_pkg::COORD_WIDTH_DEF,
	parameter int unsigned FRAC_BITS = hpt_pkg::FRAC_BITS_DEF,
	localparam int unsigned IN_W = ((4 + 4 * COORD_WIDTH + 7) / 8) * 8,
	localparam int unsigned OUT_W = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,  // entry_index, entry_value, in_x, in_y, in_z
	input  logic [1:0]       s_tuser,  // func
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,  // out_x, out_y, out_z
	output logic [5:0]       m_tuser   // form_flags, zero_w, saturated
);

	localparam int unsigned NDIG = (COORD_WIDTH + 31) / 32;
	localparam int unsigned DI_W = (NDIG > 1) ? $clog2(NDIG) : 1;
	localparam int unsigned ACC_W = 2 * COORD_WIDTH + 2;
	localparam logic [COORD_WIDTH-1:0] ONE = COORD_WIDTH'(1) << FRAC_BITS;
	localparam logic [COORD_WIDTH-1:0] MAX_C = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
	localparam logic [COORD_WIDTH-1:0] MIN_C = {1'b1, {(COORD_WIDTH - 1){1'b0}}};
	localparam logic [ACC_W-1:0] ROUND_C = ACC_W'(1) << (FRAC_BITS - 1);
	localparam int unsigned HI_LO = FRAC_BITS + COORD_WIDTH - 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_ISSUE,
		S_DRAIN,
		S_ROW,
		S_DIV,
		S_OUT
	} state_t;

	state_t                        state_q;
	logic [1:0]                    row_q;
	logic [1:0]                    col_q;
	logic [DI_W-1:0]               da_q;
	logic [DI_W-1:0]               db_q;
	logic                          drain_q;
	logic                          point_q;
	logic                          persp_q;
	logic signed [COORD_WIDTH-1:0] x_q;
	logic signed [COORD_WIDTH-1:0] y_q;
	logic signed [COORD_WIDTH-1:0] z_q;
	logic [COORD_WIDTH-1:0]        res_q [3];
	logic [ACC_W-1:0]              w_q;
	logic                          sat_q;
	logic                          zw_q;
	logic [15:0]                   dev_q;
	logic [COORD_WIDTH-1:0]        mat_q [16];
	logic                          m_tvalid_q;
	logic [OUT_W-1:0]              m_tdata_q;
	logic [5:0]                    m_tuser_q;

	logic                          accept;
	logic [1:0]                    func;
	logic [3:0]                    entry_index;
	logic [COORD_WIDTH-1:0]        entry_value;
	logic signed [COORD_WIDTH-1:0] in_x;
	logic signed [COORD_WIDTH-1:0] in_y;
	logic signed [COORD_WIDTH-1:0] in_z;
	logic [3:0]                    form;
	logic [3:0]                    rd_idx;
	logic [COORD_WIDTH-1:0]        rd_val;
	logic signed [COORD_WIDTH-1:0] coord_sel;
	logic [ACC_W-1:0]              init_val;
	logic [ACC_W-1:0]              acc;
	hpt_pkg::mac_ctrl_t            mac_ctrl;
	logic                          last_step;
	logic [ACC_W-HI_LO-1:0]        acc_hi;
	logic                          in_range;
	logic [COORD_WIDTH-1:0]        rnd_val;
	logic                          div_start;
	logic [COORD_WIDTH-1:0]        div_quo;
	hpt_pkg::div_stat_t            div_stat;
	logic                          out_free;

	assign accept = s_tvalid && s_tready;
	assign func = s_tuser;
	assign entry_index = s_tdata[3:0];
	assign entry_value = s_tdata[4 +: COORD_WIDTH];
	assign in_x = s_tdata[4 + COORD_WIDTH +: COORD_WIDTH];
	assign in_y = s_tdata[4 + 2 * COORD_WIDTH +: COORD_WIDTH];
	assign in_z = s_tdata[4 + 3 * COORD_WIDTH +: COORD_WIDTH];
	assign form = hpt_pkg::form_of(dev_q);

	assign rd_idx = {row_q, (state_q == S_LOAD) ? 2'd3 : col_q};
	assign rd_val = dev_q[rd_idx] ? mat_q[rd_idx] : (hpt_pkg::is_diag(rd_idx) ? ONE : '0);

	always_comb begin
		unique case (col_q)
			2'd0: coord_sel = x_q;
			2'd1: coord_sel = y_q;
			2'd2: coord_sel = z_q;
			default: coord_sel = x_q;
		endcase
	end

	assign init_val = (point_q ? ({{(ACC_W - COORD_WIDTH){rd_val[COORD_WIDTH-1]}}, rd_val}
		<< FRAC_BITS) : '0) | (persp_q ? '0 : ROUND_C);

	assign mac_ctrl.load = state_q == S_LOAD;
	assign mac_ctrl.issue = state_q == S_ISSUE;
	assign last_step = (col_q == 2'd2) && (da_q == DI_W'(NDIG - 1)) && (db_q == DI_W'(NDIG - 1));

	assign acc_hi = acc[ACC_W-1:HI_LO];
	assign in_range = (&acc_hi) || !(|acc_hi);
	assign rnd_val = in_range ? acc[HI_LO:FRAC_BITS] : (acc[ACC_W-1] ? MIN_C : MAX_C);

	assign div_start = (state_q == S_ROW) && persp_q && (row_q != 2'd3);
	assign out_free = !m_tvalid_q || m_tready;

	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

	hpt_mac #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (mac_ctrl),
		.init  (init_val),
		.a     (rd_val),
		.b     (coord_sel),
		.da    (da_q),
		.db    (db_q),
		.acc   (acc)
	);

	hpt_div #(
		.COORD_WIDTH(COORD_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (acc),
		.den   (w_q),
		.quo   (div_quo),
		.stat  (div_stat)
	);

	always_ff @(posedge clk) begin
		if (accept && func == hpt_pkg::FUNC_WRITE) begin
			mat_q[entry_index] <= entry_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			row_q <= '0;
			col_q <= '0;
			da_q <= '0;
			db_q <= '0;
			drain_q <= 1'b0;
			point_q <= 1'b0;
			persp_q <= 1'b0;
			x_q <= '0;
			y_q <= '0;
			z_q <= '0;
			res_q <= '{default: '0};
			w_q <= '0;
			sat_q <= 1'b0;
			zw_q <= 1'b0;
			dev_q <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q <= '0;
			m_tuser_q <= '0;
		end else begin
			if (state_q == S_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (func == hpt_pkg::FUNC_WRITE) begin
							dev_q[entry_index] <= entry_value !=
								(hpt_pkg::is_diag(entry_index) ? ONE : '0);
						end else if (func == hpt_pkg::FUNC_POINT ||
							func == hpt_pkg::FUNC_VECTOR) begin
							point_q <= func == hpt_pkg::FUNC_POINT;
							persp_q <= (func == hpt_pkg::FUNC_POINT) && form[hpt_pkg::FORM_PERSP];
							row_q <= ((func == hpt_pkg::FUNC_POINT) && form[hpt_pkg::FORM_PERSP])
								? 2'd3 : 2'd0;
							x_q <= in_x;
							y_q <= in_y;
							z_q <= in_z;
							sat_q <= 1'b0;
							zw_q <= 1'b0;
							state_q <= S_LOAD;
						end
					end
				end
				S_LOAD: begin
					col_q <= '0;
					da_q <= '0;
					db_q <= '0;
					state_q <= S_ISSUE;
				end
				S_ISSUE: begin
					if (last_step) begin
						drain_q <= 1'b0;
						state_q <= S_DRAIN;
					end else if (db_q == DI_W'(NDIG - 1)) begin
						db_q <= '0;
						if (da_q == DI_W'(NDIG - 1)) begin
							da_q <= '0;
							col_q <= col_q + 2'd1;
						end else begin
							da_q <= da_q + DI_W'(1);
						end
					end else begin
						db_q <= db_q + DI_W'(1);
					end
				end
				S_DRAIN: begin
					if (drain_q) begin
						state_q <= S_ROW;
					end else begin
						drain_q <= 1'b1;
					end
				end
				S_ROW: begin
					if (persp_q && row_q == 2'd3) begin
						w_q <= acc;
						if (acc == '0) begin
							res_q[0] <= x_q;
							res_q[1] <= y_q;
							res_q[2] <= z_q;
							zw_q <= 1'b1;
							state_q <= S_OUT;
						end else begin
							row_q <= 2'd0;
							state_q <= S_LOAD;
						end
					end else if (persp_q) begin
						state_q <= S_DIV;
					end else begin
						res_q[row_q] <= rnd_val;
						sat_q <= sat_q | !in_range;
						if (row_q == 2'd2) begin
							state_q <= S_OUT;
						end else begin
							row_q <= row_q + 2'd1;
							state_q <= S_LOAD;
						end
					end
				end
				S_DIV: begin
					if (div_stat.done) begin
						res_q[row_q] <= div_quo;
						sat_q <= sat_q | div_stat.sat;
						if (row_q == 2'd2) begin
							state_q <= S_OUT;
						end else begin
							row_q <= row_q + 2'd1;
							state_q <= S_LOAD;
						end
					end
				end
				S_OUT: begin
					if (out_free) begin
						m_tdata_q <= OUT_W'({res_q[2], res_q[1], res_q[0]});
						m_tuser_q <= {sat_q, zw_q, form};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_zero_w_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[4] |-> !m_tuser[5] && m_tuser[3])
		else $error("zero divisor flagged without perspective form or with clipping");

	a_busy_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (func == hpt_pkg::FUNC_POINT || func == hpt_pkg::FUNC_VECTOR)
		|=> !s_tready)
		else $error("ready held after a transform transfer");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == S_DIV)
		else $error("quotient returned outside the division wait");

endmodule

[tb/sv/point_transform_checker.sv]
// Checker for the homogeneous point transform: predicts each result and compares output transfers.
module point_transform_checker #(
	parameter int unsigned CW = hpt_pkg::COORD_WIDTH_DEF,
	parameter int unsigned FB = hpt_pkg::FRAC_BITS_DEF,
	parameter int unsigned IN_W = ((4 + 4 * CW + 7) / 8) * 8,
	parameter int unsigned OUT_W = ((3 * CW + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,
	input  logic [1:0]       s_tuser,
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [OUT_W-1:0] m_tdata,
	input  logic [5:0]       m_tuser,
	output int               mismatches,
	output int               backlog,
	output int               compared
);

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [4*CW-1:0] wide_t;

	typedef struct packed {
		coord_t     x;
		coord_t     y;
		coord_t     z;
		logic [3:0] form;
		logic       zero_w;
		logic       sat;
	} point_result_t;

	localparam coord_t ONE_Q = coord_t'(1) <<< FB;
	localparam wide_t HIGH_W = (wide_t'(1) <<< (CW - 1)) - 1;
	localparam wide_t LOW_W = -(wide_t'(1) <<< (CW - 1));

	coord_t        entry [16];
	logic [3:0]    form_bits;
	point_result_t result_q [$];
	point_result_t want;
	point_result_t got;
	logic          bad;
	int            n_bad;
	int            n_seen;

	function automatic logic [3:0] form_now();
		logic [3:0] f;
		f[hpt_pkg::FORM_TRANSLATE] = (entry[3] | entry[7] | entry[11]) != 0;
		f[hpt_pkg::FORM_SCALE] = entry[0] != ONE_Q || entry[5] != ONE_Q || entry[10] != ONE_Q;
		f[hpt_pkg::FORM_ROTATE] =
			(entry[1] | entry[2] | entry[4] | entry[6] | entry[8] | entry[9]) != 0;
		f[hpt_pkg::FORM_PERSP] = (entry[12] | entry[13] | entry[14]) != 0 || entry[15] != ONE_Q;
		return f;
	endfunction

	function automatic wide_t row_sum(input int r, input coord_t x, y, z, input logic with_t);
		wide_t s;
		wide_t t;
		s = entry[4*r] * x + entry[4*r+1] * y + entry[4*r+2] * z;
		if (with_t) begin
			t = entry[4*r+3];
			s = s + (t <<< FB);
		end
		return s;
	endfunction

	function automatic wide_t round_q(input wide_t a);
		return (a + (wide_t'(1) <<< (FB - 1))) >>> FB;
	endfunction

	function automatic wide_t ratio(input wide_t num, input wide_t den);
		logic [4*CW-1:0] un;
		logic [4*CW-1:0] ud;
		logic [4*CW-1:0] q;
		logic [4*CW-1:0] rm;
		logic            neg;
		neg = (num < 0) != (den < 0);
		un = (num < 0) ? -num : num;
		ud = (den < 0) ? -den : den;
		un = un << FB;
		q = un / ud;
		rm = un % ud;
		if ((rm << 1) >= ud) q = q + 1;
		return neg ? -$signed(q) : $signed(q);
	endfunction

	function automatic coord_t clip(input wide_t v, inout logic sat);
		if (v > HIGH_W) begin
			sat = 1'b1;
			return coord_t'(HIGH_W);
		end
		if (v < LOW_W) begin
			sat = 1'b1;
			return coord_t'(LOW_W);
		end
		return coord_t'(v);
	endfunction

	function automatic point_result_t predict(input logic [1:0] fn, input coord_t x, y, z);
		point_result_t r;
		wide_t         w;
		coord_t        c [3];
		logic          sat;
		sat = 1'b0;
		r.form = form_bits;
		r.zero_w = 1'b0;
		if (fn == hpt_pkg::FUNC_POINT && form_bits[hpt_pkg::FORM_PERSP]) begin
			w = row_sum(3, x, y, z, 1'b1);
			if (w == 0) begin
				c[0] = x;
				c[1] = y;
				c[2] = z;
				r.zero_w = 1'b1;
			end else begin
				for (int i = 0; i < 3; i++)
					c[i] = clip(ratio(row_sum(i, x, y, z, 1'b1), w), sat);
			end
		end else begin
			for (int i = 0; i < 3; i++)
				c[i] = clip(round_q(row_sum(i, x, y, z, fn == hpt_pkg::FUNC_POINT)), sat);
		end
		r.x = c[0];
		r.y = c[1];
		r.z = c[2];
		r.sat = sat;
		return r;
	endfunction

	task automatic check_field(input string name, input logic signed [63:0] exp_v, act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			bad = 1'b1;
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) entry[i] = (i % 5 == 0) ? ONE_Q : '0;
			form_bits = '0;
			result_q.delete();
			n_bad = 0;
			n_seen = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				case (s_tuser)
					hpt_pkg::FUNC_WRITE: begin
						entry[s_tdata[3:0]] = s_tdata[4 +: CW];
						form_bits = form_now();
					end
					hpt_pkg::FUNC_POINT, hpt_pkg::FUNC_VECTOR: begin
						result_q.push_back(predict(s_tuser, s_tdata[4+CW +: CW],
							s_tdata[4+2*CW +: CW], s_tdata[4+3*CW +: CW]));
					end
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got.x = m_tdata[0 +: CW];
				got.y = m_tdata[CW +: CW];
				got.z = m_tdata[2*CW +: CW];
				got.form = m_tuser[3:0];
				got.zero_w = m_tuser[4];
				got.sat = m_tuser[5];
				if (result_q.size() == 0) begin
					$error("result transfer with no transform outstanding");
					n_bad++;
				end else begin
					want = result_q.pop_front();
					bad = 1'b0;
					check_field("out_x", want.x, got.x);
					check_field("out_y", want.y, got.y);
					check_field("out_z", want.z, got.z);
					check_field("form_flags", want.form, got.form);
					check_field("zero_w", want.zero_w, got.zero_w);
					check_field("saturated", want.sat, got.sat);
					if (bad) n_bad++;
					n_seen++;
				end
			end
		end
		mismatches <= n_bad;
		compared <= n_seen;
		backlog <= result_q.size();
	end

endmodule

[tb/sv/tb_homogeneous_point_transform.sv]
// Testbench top for the homogeneous point transform: clock, reset, stimulus and verdict.
module tb_homogeneous_point_transform;

	localparam int unsigned CW = hpt_pkg::COORD_WIDTH_DEF;
	localparam int unsigned FB = hpt_pkg::FRAC_BITS_DEF;
	localparam int unsigned IN_W = ((4 + 4 * CW + 7) / 8) * 8;
	localparam int unsigned OUT_W = ((3 * CW + 7) / 8) * 8;
	localparam logic [1:0] FUNC_NONE = 2'd3;
	localparam logic [CW-1:0] ONE = CW'(1) << FB;
	localparam logic [CW-1:0] MAXC = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] MINC = {1'b1, {(CW-1){1'b0}}};
	localparam int unsigned RANDOM_ITEMS = 900;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;
	logic [1:0]       s_tuser;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;
	logic [5:0]       m_tuser;

	int mismatches;
	int backlog;
	int compared;
	int n_items;
	int n_writes;
	int n_points;
	int n_vectors;
	int n_ignored;
	bit sender_steady;

	always #5 clk = ~clk;

	homogeneous_point_transform dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	point_transform_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.mismatches (mismatches),
		.backlog    (backlog),
		.compared   (compared)
	);

	function automatic int unsigned idle_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (sender_steady || roll < 55) return 0;
		if (roll < 88) return $urandom_range(1, 3);
		if (roll < 97) return $urandom_range(4, 12);
		return $urandom_range(30, 80);
	endfunction

	function automatic logic [CW-1:0] any_value(input int unsigned span);
		int v;
		case ($urandom_range(0, 9))
			0: return '0;
			1: return ONE;
			2: return -ONE;
			3: return MAXC;
			4: return MINC;
			5, 6, 7: begin
				v = int'($urandom_range(0, 2 * span)) - int'(span);
				return v;
			end
			default: return $urandom();
		endcase
	endfunction

	task automatic send_item(input logic [1:0] fn, input logic [3:0] idx,
		input logic [CW-1:0] val, x, y, z);
		int unsigned gap;
		s_tuser <= fn;
		s_tdata <= {{(IN_W-4-4*CW){1'b0}}, z, y, x, val, idx};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		case (fn)
			hpt_pkg::FUNC_WRITE: n_writes++;
			hpt_pkg::FUNC_POINT: n_points++;
			hpt_pkg::FUNC_VECTOR: n_vectors++;
			default: n_ignored++;
		endcase
		if (fn != FUNC_NONE) n_items++;
		gap = idle_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic put_entry(input logic [3:0] idx, input logic [CW-1:0] val);
		send_item(hpt_pkg::FUNC_WRITE, idx, val, $urandom(), $urandom(), $urandom());
	endtask

	task automatic xform(input logic [1:0] fn, input logic [CW-1:0] x, y, z);
		send_item(fn, 4'($urandom_range(0, 15)), $urandom(), x, y, z);
	endtask

	initial begin
		int unsigned roll;
		int unsigned len;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			roll = $urandom_range(0, 99);
			if (roll < 10) begin
				m_tready <= 1'b1;
				len = $urandom_range(100, 300);
			end else if (roll < 55) begin
				m_tready <= 1'b1;
				len = $urandom_range(1, 6);
			end else if (roll < 93) begin
				m_tready <= 1'b0;
				len = $urandom_range(1, 3);
			end else begin
				m_tready <= 1'b0;
				len = $urandom_range(20, 70);
			end
			repeat (len) @(posedge clk);
		end
	end

	initial begin
		int unsigned roll;
		int unsigned k;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= hpt_pkg::FUNC_WRITE;
		arst_n <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		xform(hpt_pkg::FUNC_POINT, MAXC, MINC, '0);
		xform(hpt_pkg::FUNC_VECTOR, MINC, MAXC, ONE);
		send_item(FUNC_NONE, 4'($urandom_range(0, 15)), $urandom(), $urandom(), $urandom(),
			$urandom());
		put_entry(4'd3, 32'h0005_8000);
		xform(hpt_pkg::FUNC_POINT, ONE, -ONE, 2 * ONE);
		xform(hpt_pkg::FUNC_VECTOR, ONE, -ONE, 2 * ONE);
		put_entry(4'd0, 2 * ONE);
		xform(hpt_pkg::FUNC_POINT, MAXC, MINC, MAXC);
		put_entry(4'd0, ONE >> 1);
		xform(hpt_pkg::FUNC_POINT, 1, '0, '0);
		xform(hpt_pkg::FUNC_POINT, '1, '0, '0);
		put_entry(4'd1, -(ONE >> 1));
		xform(hpt_pkg::FUNC_VECTOR, $urandom(), $urandom(), $urandom());
		put_entry(4'd14, ONE);
		put_entry(4'd15, '0);
		xform(hpt_pkg::FUNC_POINT, ONE, ONE, '0);
		xform(hpt_pkg::FUNC_POINT, 3 * ONE, -ONE, 2 * ONE);
		xform(hpt_pkg::FUNC_POINT, ONE, ONE, -ONE);
		xform(hpt_pkg::FUNC_POINT, MAXC, MINC, 1);
		put_entry(4'd12, MAXC);
		put_entry(4'd15, MINC);
		xform(hpt_pkg::FUNC_POINT, MINC, MAXC, MINC);
		xform(hpt_pkg::FUNC_VECTOR, MAXC, MAXC, MAXC);

		n_items = 0;
		while (n_items < RANDOM_ITEMS) begin
			sender_steady = ($urandom_range(0, 4) == 0);
			roll = $urandom_range(0, 99);
			if (roll < 4) begin
				for (int i = 0; i < 16; i++) put_entry(4'(i), (i % 5 == 0) ? ONE : '0);
			end else if (roll < 22) begin
				put_entry(4'd12, '0);
				put_entry(4'd13, '0);
				put_entry(4'd14, '0);
				put_entry(4'd15, ONE);
				k = $urandom_range(0, 3);
				repeat (k) put_entry(4'($urandom_range(0, 11)), any_value(1 << 18));
			end else if (roll < 45) begin
				for (int i = 12; i < 16; i++)
					put_entry(4'(i), ($urandom_range(0, 2) == 0) ? '0 : any_value(1 << 17));
			end else if (roll < 52) begin
				put_entry(4'd12, '0);
				put_entry(4'd13, '0);
				put_entry(4'd14, '0);
				put_entry(4'd15, '0);
			end else if (roll < 80) begin
				k = $urandom_range(1, 4);
				repeat (k) put_entry(4'($urandom_range(0, 15)), any_value(1 << 18));
			end
			k = $urandom_range(1, 8);
			repeat (k) begin
				if ($urandom_range(0, 32) == 0)
					send_item(FUNC_NONE, 4'($urandom_range(0, 15)), $urandom(), $urandom(),
						$urandom(), $urandom());
				else
					xform(($urandom_range(0, 4) < 3) ? hpt_pkg::FUNC_POINT : hpt_pkg::FUNC_VECTOR,
						any_value(1 << 24), any_value(1 << 24), any_value(1 << 24));
			end
		end
		s_tvalid <= 1'b0;

		while (backlog != 0) @(posedge clk);
		repeat (300) @(posedge clk);

		$display("Sent %0d matrix writes, %0d points, %0d vectors and %0d unused-code items",
			n_writes, n_points, n_vectors, n_ignored);
		$display("Compared %0d transform results field by field", compared);
		if (mismatches == 0 && backlog == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#30_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

[homogeneous_point_transform.f]
src/hpt_pkg.sv
src/hpt_mac.sv
src/hpt_div.sv
src/homogeneous_point_transform.sv
tb/sv/point_transform_checker.sv
tb/sv/tb_homogeneous_point_transform.sv
